// File: hdl/tps_pkg.sv
// task priority scheduler: shared beat types, codes and cell control types
// no dependencies; used by tps_cell, tps_chain and task_priority_scheduler_top
package tps_pkg;

    localparam int ID_W   = 17;
    localparam int USER_W = 17;
    localparam int PRIO_W = 30;
    localparam int ACT_W  = 2;
    localparam int STAT_W = 3;

    // action codes
    localparam logic [ACT_W-1:0] ACT_ADD    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_EDIT   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;
    localparam logic [ACT_W-1:0] ACT_SERVE  = 2'd3;

    // status codes
    localparam logic [STAT_W-1:0] ST_DONE    = 3'd0;
    localparam logic [STAT_W-1:0] ST_SERVED  = 3'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd3;
    localparam logic [STAT_W-1:0] ST_UNKNOWN = 3'd4;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [ID_W-1:0]   task_id;
        logic [USER_W-1:0] user_id;
        logic [PRIO_W-1:0] priority_req;
    } cmd_beat_t;

    typedef struct packed {
        logic [USER_W-1:0] served_user;
        logic [STAT_W-1:0] status;
    } rsp_beat_t;

    // one task as held in a cell
    typedef struct packed {
        logic              valid;
        logic [PRIO_W-1:0] prio;
        logic [ID_W-1:0]   task_id;
        logic [USER_W-1:0] user;
    } entry_t;

    // what the whole row does this cycle
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_DELETE,
        OP_SHIFT,
        OP_INSERT
    } cell_op_t;

    // broadcast to every cell
    typedef struct packed {
        cell_op_t          op;
        logic [PRIO_W-1:0] prio;
        logic [ID_W-1:0]   task_id;
        logic [USER_W-1:0] user;
    } cell_ctl_t;

    // summary from the row back to the sequencer
    typedef struct packed {
        logic              any_hit;
        logic [PRIO_W-1:0] hit_prio;
        logic [USER_W-1:0] hit_user;
        entry_t            head;
        logic              full;
    } chain_stat_t;

endpackage

// File: hdl/tps_cell.sv
// task priority scheduler: one cell of the sorted row
// holds one task and moves it toward a neighbor on delete, shift or insert; uses tps_pkg
module tps_cell
(
    input  logic              clk,
    input  logic              rst_n,
    input  tps_pkg::cell_ctl_t ctl,
    input  tps_pkg::entry_t   left,
    input  logic              left_gt,
    input  tps_pkg::entry_t   right,
    output tps_pkg::entry_t   held,
    output logic              gt,
    output logic              hit
);

    logic            valid_reg;
    logic            valid_next;
    tps_pkg::entry_t data_reg;
    tps_pkg::entry_t data_next;

    assign held = '{valid: valid_reg, prio: data_reg.prio, task_id: data_reg.task_id,
                    user: data_reg.user};

    // key compare against the broadcast key, priority first then id
    assign gt  = valid_reg && ({data_reg.prio, data_reg.task_id} > {ctl.prio, ctl.task_id});
    assign hit = valid_reg && (data_reg.task_id == ctl.task_id);

    // next content from own, neighbor or broadcast
    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        case (ctl.op)
            tps_pkg::OP_HOLD:
            begin
                data_next  = data_reg;
                valid_next = valid_reg;
            end
            tps_pkg::OP_DELETE:
            begin
                if (!gt)
                begin
                    data_next  = right;
                    valid_next = right.valid;
                end
            end
            tps_pkg::OP_SHIFT:
            begin
                data_next  = right;
                valid_next = right.valid;
            end
            tps_pkg::OP_INSERT:
            begin
                if (!gt)
                begin
                    if (left_gt)
                    begin
                        data_next  = '{valid: 1'b1, prio: ctl.prio, task_id: ctl.task_id,
                                       user: ctl.user};
                        valid_next = 1'b1;
                    end
                    else
                    begin
                        data_next  = left;
                        valid_next = left.valid;
                    end
                end
            end
            default:
            begin
                data_next  = data_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

// File: hdl/tps_chain.sv
// task priority scheduler: row of cells kept sorted by priority then id, highest first
// depends on tps_pkg and tps_cell
module tps_chain #(
    parameter int ENTRIES = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  tps_pkg::cell_ctl_t    ctl,
    output tps_pkg::chain_stat_t  stat
);

    tps_pkg::entry_t           ent [ENTRIES];
    logic [ENTRIES-1:0]        gt_vec;
    logic [ENTRIES-1:0]        hit_vec;

    localparam tps_pkg::entry_t EMPTY_ENTRY = '0;

    // row of cells, each wired to its neighbors
    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++)
        begin : g_cell
            tps_pkg::entry_t left_ent;
            tps_pkg::entry_t right_ent;
            logic            left_gt;

            if (g == 0)
            begin : g_first
                assign left_ent = EMPTY_ENTRY;
                assign left_gt  = 1'b1;
            end
            else
            begin : g_mid
                assign left_ent = ent[g-1];
                assign left_gt  = gt_vec[g-1];
            end

            if (g == ENTRIES - 1)
            begin : g_last
                assign right_ent = EMPTY_ENTRY;
            end
            else
            begin : g_inner
                assign right_ent = ent[g+1];
            end

            tps_cell u_cell
            (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctl     (ctl),
                .left    (left_ent),
                .left_gt (left_gt),
                .right   (right_ent),
                .held    (ent[g]),
                .gt      (gt_vec[g]),
                .hit     (hit_vec[g])
            );
        end
    endgenerate

    // id lookup: ids are unique so at most one cell hits
    always_comb
    begin
        stat.any_hit  = 1'b0;
        stat.hit_prio = '0;
        stat.hit_user = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            stat.any_hit  = stat.any_hit | hit_vec[i];
            stat.hit_prio = stat.hit_prio | ({tps_pkg::PRIO_W{hit_vec[i]}} & ent[i].prio);
            stat.hit_user = stat.hit_user | ({tps_pkg::USER_W{hit_vec[i]}} & ent[i].user);
        end
        stat.head = ent[0];
        stat.full = ent[ENTRIES-1].valid;
    end

endmodule

// File: hdl/task_priority_scheduler_top.sv
// task priority scheduler top: sequencer, response register and the sorted cell row
// depends on tps_pkg, tps_chain and tps_cell
//
//  channel | valid     | stall     | beat
//  command | cmd_valid | cmd_stall | cmd (action, task_id, user_id, priority_req)
//  result  | rsp_valid | rsp_stall | rsp (served_user, status)
//
// serve, remove, an add of a new id to a full row and an edit of an unknown id get their
// result from the lookup state S_DEL; other adds and edits go on to an insert pass
// (S_INS), preceded by a delete pass in S_DEL if the id is held. the row is kept sorted,
// highest first. the response register holds the result until taken; a new command is
// taken once the sequencer is idle and the response register is free or being drained,
// so no new command is taken while the last one is still in the sequencer.
// reset clears all cell valid flags at once; no clearing pass.
module task_priority_scheduler_top #(
    parameter int ENTRIES = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  tps_pkg::cmd_beat_t   cmd,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output tps_pkg::rsp_beat_t   rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DEL,
        S_INS
    } state_t;

    state_t                       state_reg;
    state_t                       state_next;
    tps_pkg::cmd_beat_t           cmd_reg;
    tps_pkg::cmd_beat_t           cmd_next;
    logic [tps_pkg::USER_W-1:0]   ins_user_reg;
    logic [tps_pkg::USER_W-1:0]   ins_user_next;
    logic                         rsp_valid_reg;
    logic                         rsp_valid_next;
    tps_pkg::rsp_beat_t           rsp_reg;
    tps_pkg::rsp_beat_t           rsp_next;
    tps_pkg::cell_ctl_t           ctl;
    tps_pkg::chain_stat_t         stat;
    logic                         take;

    assign cmd_stall = !((state_reg == S_IDLE) && (!rsp_valid_reg || !rsp_stall));
    assign take      = cmd_valid && !cmd_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    tps_chain #(.ENTRIES(ENTRIES)) u_chain
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .stat  (stat)
    );

    // sequencer and row control
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        ins_user_next  = ins_user_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        ctl.op         = tps_pkg::OP_HOLD;
        ctl.prio       = stat.hit_prio;
        ctl.task_id    = cmd_reg.task_id;
        ctl.user       = ins_user_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    cmd_next      = cmd;
                    ins_user_next = cmd.user_id;
                    state_next    = S_DEL;
                end
            end
            S_DEL:
            begin
                rsp_next = '{served_user: '0, status: tps_pkg::ST_DONE};
                case (cmd_reg.action)
                    tps_pkg::ACT_ADD:
                    begin
                        if (stat.any_hit)
                        begin
                            ctl.op     = tps_pkg::OP_DELETE;
                            state_next = S_INS;
                        end
                        else if (stat.full)
                        begin
                            rsp_next.status = tps_pkg::ST_FULL;
                            rsp_valid_next  = 1'b1;
                            state_next      = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_INS;
                        end
                    end
                    tps_pkg::ACT_EDIT:
                    begin
                        if (stat.any_hit)
                        begin
                            ctl.op        = tps_pkg::OP_DELETE;
                            ins_user_next = stat.hit_user;
                            state_next    = S_INS;
                        end
                        else
                        begin
                            rsp_next.status = tps_pkg::ST_UNKNOWN;
                            rsp_valid_next  = 1'b1;
                            state_next      = S_IDLE;
                        end
                    end
                    tps_pkg::ACT_REMOVE:
                    begin
                        if (stat.any_hit)
                        begin
                            ctl.op = tps_pkg::OP_DELETE;
                        end
                        else
                        begin
                            rsp_next.status = tps_pkg::ST_UNKNOWN;
                        end
                        rsp_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                    tps_pkg::ACT_SERVE:
                    begin
                        if (stat.head.valid)
                        begin
                            ctl.op   = tps_pkg::OP_SHIFT;
                            rsp_next = '{served_user: stat.head.user,
                                         status: tps_pkg::ST_SERVED};
                        end
                        else
                        begin
                            rsp_next.status = tps_pkg::ST_EMPTY;
                        end
                        rsp_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_INS:
            begin
                ctl.op         = tps_pkg::OP_INSERT;
                ctl.prio       = cmd_reg.priority_req;
                rsp_next       = '{served_user: '0, status: tps_pkg::ST_DONE};
                rsp_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // command and response payload
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        ins_user_reg <= ins_user_next;
        rsp_reg      <= rsp_next;
    end

endmodule
